// ----- hdl/kdt_pkg.sv -----
// Package for the dual tilt/bias Kalman filter.
// Holds the lane state type, status structs, register codes and the
// fixed-point helpers (saturation and Q8.24 rounding). No dependencies.
`default_nettype none

package kdt_pkg;

  // Per-lane sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_RATE, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_DIV,
    S_M7, S_M8, S_M9, S_M10, S_M11, S_M12, S_M13, S_DONE
  } kdt_state_e;

  typedef logic signed [31:0] word_t;

  // Noise terms handed to one lane
  typedef struct packed {
    logic [30:0] q_angle;
    logic [30:0] q_bias;
    logic [30:0] r_meas;
  } kdt_noise_t;

  // Lane status seen by the merge stage
  typedef struct packed {
    logic idle;
    logic done;
  } kdt_status_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_Q_ANGLE_L = 3'd0;
  localparam logic [2:0] CFG_Q_BIAS_L  = 3'd1;
  localparam logic [2:0] CFG_R_MEAS_L  = 3'd2;
  localparam logic [2:0] CFG_Q_ANGLE_R = 3'd3;
  localparam logic [2:0] CFG_Q_BIAS_R  = 3'd4;
  localparam logic [2:0] CFG_R_MEAS_R  = 3'd5;
  localparam logic [2:0] CFG_TIME_STEP = 3'd6;

  // Reset values of the registers
  localparam logic [30:0] RST_Q_ANGLE   = 31'd16777;
  localparam logic [30:0] RST_Q_BIAS    = 31'd50332;
  localparam logic [30:0] RST_R_MEAS    = 31'd503316;
  localparam logic [24:0] RST_TIME_STEP = 25'd33554;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  // Clamp a wide signed value to the 32-bit range
  function automatic word_t sat32(input logic signed [47:0] v);
    word_t r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = WORD_MAX;
    end else if (v < -48'sh0000_8000_0000) begin
      r = WORD_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Drop 24 fraction bits, round to nearest with ties upward
  function automatic logic signed [44:0] round24(input logic signed [67:0] p);
    logic signed [68:0] s;
    s = 69'(p) + 69'sd8388608;
    return s[68:24];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/kdt_div.sv -----
// Gain divider: (num * 2^24) / den, truncated toward zero, saturated.
// Restoring division, one quotient bit per cycle. Uses kdt_pkg.
`default_nettype none

module kdt_div
  import kdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  word_t       num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output word_t       quot_o
);

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [55:0] rem_q, rem_d;
  logic [61:0] dvs_q, dvs_d;
  logic [30:0] quo_q, quo_d;
  logic        neg_q, neg_d;
  word_t       res_q, res_d;

  logic [31:0] mag;
  logic        ovf;
  logic        ge;
  logic [30:0] quo_fin;

  // Magnitude of the numerator and early overflow test
  always_comb begin
    mag     = num_i[31] ? (~num_i + 32'd1) : num_i;
    ovf     = {7'b0, mag} >= {den_i, 7'b0};
    ge      = {6'b0, rem_q} >= dvs_q;
    quo_fin = {quo_q[29:0], ge};
  end

  // Load, iterate, finish
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    res_d  = res_q;
    if (start_i) begin
      neg_d = num_i[31];
      if (ovf) begin
        res_d  = num_i[31] ? WORD_MIN : WORD_MAX;
        busy_d = 1'b0;
      end else begin
        rem_d  = {mag, 24'b0};
        dvs_d  = {den_i, 30'b0};
        quo_d  = '0;
        cnt_d  = 5'd30;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dvs_q[55:0];
      end
      quo_d = quo_fin;
      dvs_d = {1'b0, dvs_q[61:1]};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        res_d  = neg_q ? (32'd0 - {1'b0, quo_fin}) : {1'b0, quo_fin};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign busy_o = busy_q;
  assign quot_o = res_q;

endmodule

`default_nettype wire

// ----- hdl/kdt_lane.sv -----
// One filter lane: angle/bias state, 2x2 covariance, a shared multiplier
// stepped by a sequencer and two gain dividers. Uses kdt_pkg, kdt_div.
`default_nettype none

module kdt_lane
  import kdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        take_i,
  input  word_t       gyro_i,
  input  word_t       tilt_i,
  input  kdt_noise_t  noise_i,
  input  logic [24:0] dt_i,
  output kdt_status_t status_o,
  output word_t       angle_o,
  output word_t       rate_o
);

  kdt_state_e state_q, state_d;

  word_t gyro_q, tilt_q, rate_q, y_q, p00o_q, p01o_q;
  word_t angle_q, angle_d, bias_q, bias_d;
  word_t p0_q, p0_d, p1_q, p1_d, p2_q, p2_d, p3_q, p3_d;
  logic signed [34:0] inner_q;
  logic               den_pos_q;
  logic signed [67:0] prod_q;

  logic signed [34:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [44:0] rnd;
  logic signed [33:0] den_w;
  logic               den_pos;
  logic               div_start;
  logic               busy0, busy1;
  word_t              q0, q1, k0, k1;
  logic signed [32:0] dt_s;

  assign dt_s = $signed({8'b0, dt_i});
  assign rnd  = round24(prod_q);
  assign k0   = den_pos_q ? q0 : '0;
  assign k1   = den_pos_q ? q1 : '0;

  // Innovation denominator P00 + R
  assign den_w     = 34'(p0_q) + $signed({3'b0, noise_i.r_meas});
  assign den_pos   = !den_w[33] && (den_w != '0);
  assign div_start = (state_q == S_M6) && den_pos;

  kdt_div u_div0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (p0_q),
    .den_i  (den_w[31:0]),
    .busy_o (busy0),
    .quot_o (q0)
  );

  kdt_div u_div1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (p2_q),
    .den_i  (den_w[31:0]),
    .busy_o (busy1),
    .quot_o (q1)
  );

  // Select multiplier operands for the step being issued
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_M1: begin
        mul_a = 35'(rate_q);
        mul_b = dt_s;
      end
      S_M2: begin
        mul_a = 35'(dt_s);
        mul_b = 33'(p3_q);
      end
      S_M4: begin
        mul_a = inner_q;
        mul_b = dt_s;
      end
      S_M5: begin
        mul_a = $signed({4'b0, noise_i.q_bias});
        mul_b = dt_s;
      end
      S_M7: begin
        mul_a = 35'(k0);
        mul_b = 33'(y_q);
      end
      S_M8: begin
        mul_a = 35'(k1);
        mul_b = 33'(y_q);
      end
      S_M9: begin
        mul_a = 35'(k0);
        mul_b = 33'(p00o_q);
      end
      S_M10: begin
        mul_a = 35'(k1);
        mul_b = 33'(p00o_q);
      end
      S_M11: begin
        mul_a = 35'(k0);
        mul_b = 33'(p01o_q);
      end
      S_M12: begin
        mul_a = 35'(k1);
        mul_b = 33'(p01o_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Next state and state updates
  always_comb begin
    state_d = state_q;
    angle_d = angle_q;
    bias_d  = bias_q;
    p0_d    = p0_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    p3_d    = p3_q;
    case (state_q)
      S_IDLE:  if (start_i) state_d = S_RATE;
      S_RATE:  state_d = S_M1;
      S_M1:    state_d = S_M2;
      S_M2: begin
        angle_d = sat32(48'(angle_q) + 48'(rnd));
        state_d = S_M3;
      end
      S_M3: begin
        p1_d    = sat32(48'(p1_q) - 48'(rnd));
        p2_d    = sat32(48'(p2_q) - 48'(rnd));
        state_d = S_M4;
      end
      S_M4:    state_d = S_M5;
      S_M5: begin
        p0_d    = sat32(48'(p0_q) + 48'(rnd));
        state_d = S_M6;
      end
      S_M6: begin
        p3_d    = sat32(48'(p3_q) + 48'(rnd));
        state_d = S_DIV;
      end
      S_DIV:   if (!busy0 && !busy1) state_d = S_M7;
      S_M7:    state_d = S_M8;
      S_M8: begin
        angle_d = sat32(48'(angle_q) + 48'(rnd));
        state_d = S_M9;
      end
      S_M9: begin
        bias_d  = sat32(48'(bias_q) + 48'(rnd));
        state_d = S_M10;
      end
      S_M10: begin
        p0_d    = sat32(48'(p0_q) - 48'(rnd));
        state_d = S_M11;
      end
      S_M11: begin
        p2_d    = sat32(48'(p2_q) - 48'(rnd));
        state_d = S_M12;
      end
      S_M12: begin
        p1_d    = sat32(48'(p1_q) - 48'(rnd));
        state_d = S_M13;
      end
      S_M13: begin
        p3_d    = sat32(48'(p3_q) - 48'(rnd));
        state_d = S_DONE;
      end
      S_DONE:  if (take_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Filter state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      angle_q <= '0;
      bias_q  <= '0;
      p0_q    <= '0;
      p1_q    <= '0;
      p2_q    <= '0;
      p3_q    <= '0;
    end else begin
      state_q <= state_d;
      angle_q <= angle_d;
      bias_q  <= bias_d;
      p0_q    <= p0_d;
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      p3_q    <= p3_d;
    end
  end

  // Working registers of one step
  always_ff @(posedge clk_i) begin
    prod_q <= 68'(mul_a) * 68'(mul_b);
    if (state_q == S_IDLE && start_i) begin
      gyro_q <= gyro_i;
      tilt_q <= tilt_i;
    end
    if (state_q == S_RATE) begin
      rate_q <= sat32(48'(gyro_q) - 48'(bias_q));
    end
    if (state_q == S_M3) begin
      inner_q <= 35'(rnd) - 35'(p1_q) - 35'(p2_q)
               + $signed({4'b0, noise_i.q_angle});
    end
    if (state_q == S_M6) begin
      den_pos_q <= den_pos;
      y_q       <= sat32(48'(tilt_q) - 48'(angle_q));
      p00o_q    <= p0_q;
      p01o_q    <= p1_q;
    end
  end

  assign status_o.idle = (state_q == S_IDLE);
  assign status_o.done = (state_q == S_DONE);
  assign angle_o       = angle_q;
  assign rate_o        = rate_q;

endmodule

`default_nettype wire

// ----- hdl/dual_kalman_tilt_bias_filter_top.sv -----
// Dual tilt/bias Kalman filter, top level: register file, two lanes and
// the merging output register. Uses kdt_pkg and kdt_lane.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one word carrying gyro
//   rate and accelerometer tilt for the left and right sensor, Q16.16.
//   Output channel (out_valid_o / out_stall_i) gives filtered angles and
//   bias-corrected rates for both sides, one word per input word.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes noise terms
//   and time step by index; write only while the filter is idle.
//   Each word passes through the rate and predict steps on the lane
//   multiplier, the bit-serial gain division, the update steps and the
//   hand-over to the output register. When the gain denominator is not
//   positive the division is skipped. Words are taken one at a time: the
//   next word waits until both lanes have handed over their result, and
//   waits longer when the output stalls.
//   Reset clears angles, biases and covariances to zero and loads the
//   default noise terms and time step.
//   A stalled output holds its word; the lanes hold their finished result
//   and keep stall raised until the output register is free.
`default_nettype none

module dual_kalman_tilt_bias_filter_top
  import kdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  word_t       gyro_rate_left_i,
  input  word_t       accel_tilt_left_i,
  input  word_t       gyro_rate_right_i,
  input  word_t       accel_tilt_right_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output word_t       angle_left_o,
  output word_t       rate_left_o,
  output word_t       angle_right_o,
  output word_t       rate_right_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  kdt_noise_t  noise_l_q, noise_r_q;
  logic [24:0] dt_q;

  kdt_status_t st_l, st_r;
  word_t       ang_l, rt_l, ang_r, rt_r;
  logic        start, take;
  logic        out_valid_q;
  word_t       angle_l_q, rate_l_q, angle_r_q, rate_r_q;

  assign cfg_ready_o = 1'b1;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_l_q <= '{q_angle: RST_Q_ANGLE, q_bias: RST_Q_BIAS, r_meas: RST_R_MEAS};
      noise_r_q <= '{q_angle: RST_Q_ANGLE, q_bias: RST_Q_BIAS, r_meas: RST_R_MEAS};
      dt_q      <= RST_TIME_STEP;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_Q_ANGLE_L: noise_l_q.q_angle <= cfg_data_i[30:0];
        CFG_Q_BIAS_L:  noise_l_q.q_bias  <= cfg_data_i[30:0];
        CFG_R_MEAS_L:  noise_l_q.r_meas  <= cfg_data_i[30:0];
        CFG_Q_ANGLE_R: noise_r_q.q_angle <= cfg_data_i[30:0];
        CFG_Q_BIAS_R:  noise_r_q.q_bias  <= cfg_data_i[30:0];
        CFG_R_MEAS_R:  noise_r_q.r_meas  <= cfg_data_i[30:0];
        CFG_TIME_STEP: dt_q              <= cfg_data_i[24:0];
        default:       ;
      endcase
    end
  end

  // Accept a word only when both lanes are free
  assign in_stall_o = !(st_l.idle && st_r.idle);
  assign start      = in_valid_i && !in_stall_o;

  kdt_lane u_lane_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .take_i  (take),
    .gyro_i  (gyro_rate_left_i),
    .tilt_i  (accel_tilt_left_i),
    .noise_i (noise_l_q),
    .dt_i    (dt_q),
    .status_o(st_l),
    .angle_o (ang_l),
    .rate_o  (rt_l)
  );

  kdt_lane u_lane_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .take_i  (take),
    .gyro_i  (gyro_rate_right_i),
    .tilt_i  (accel_tilt_right_i),
    .noise_i (noise_r_q),
    .dt_i    (dt_q),
    .status_o(st_r),
    .angle_o (ang_r),
    .rate_o  (rt_r)
  );

  // Merge both lanes into the output register when it is free
  assign take = st_l.done && st_r.done && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      angle_l_q <= ang_l;
      rate_l_q  <= rt_l;
      angle_r_q <= ang_r;
      rate_r_q  <= rt_r;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign angle_left_o  = angle_l_q;
  assign rate_left_o   = rate_l_q;
  assign angle_right_o = angle_r_q;
  assign rate_right_o  = rate_r_q;

endmodule

`default_nettype wire

// ----- hdl/kdt_checker.sv -----
// Port-level checks for the dual tilt/bias Kalman filter top level,
// bound to it below. Uses kdt_pkg for the word type.
`default_nettype none

module kdt_port_checker
  import kdt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input word_t       angle_left_o,
  input word_t       rate_right_o
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(angle_left_o) && $stable(rate_right_o))
    else $error("output payload changed while stalled");

  // One word at a time: stall rises right after a word is taken
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while filter busy");

  // A result never appears the cycle after a word is taken
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind dual_kalman_tilt_bias_filter_top kdt_port_checker u_kdt_checker (.*);

`default_nettype wire
